FILE: rtl/fbfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_pkg: shared types and constants of the block pool allocator
// Command and status codes, register indexes, field widths and the
// control and status groups exchanged with the free stack.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int MAX_BLOCKS_DEFAULT = 64;

  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 7;
  localparam int INDEX_W  = 6;
  localparam int OFFSET_W = 22;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET  = 16'd64;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_FREE_ALL = 2'd2,
    CMD_INIT     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE  = 1'd0,
    REG_BLOCK_COUNT = 1'd1
  } cfg_reg_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [SIZE_W-1:0]  blk_bytes;
    logic [COUNT_W-1:0] eff_count;
  } cfg_t;

  // one operation on the free stack
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               rebuild;
    logic [INDEX_W-1:0] push_idx;
    logic [COUNT_W-1:0] fill_count;
  } stk_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] free_count;
    logic [INDEX_W-1:0] top;
  } stk_stat_t;

  // clamp a block count to the pool depth
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] cnt,
                                                     input int max_blocks);
    logic [COUNT_W-1:0] res;
    res = cnt;
    if (int'(cnt) > max_blocks) begin
      res = COUNT_W'(max_blocks);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fbfl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_cmd_if / fbfl_rsp_if: command and response channels
// Valid/ready channels carrying one command word or one response word.
// ----------------------------------------------------------------------------
interface fbfl_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] request_size;
  logic [5:0]  block_index;

  modport source (output valid, command, request_size, block_index, input ready);
  modport sink   (input valid, command, request_size, block_index, output ready);
endinterface

interface fbfl_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  granted_index;
  logic [21:0] granted_offset;
  logic [6:0]  free_count;
  logic [6:0]  min_free;

  modport source (output valid, status, granted_index, granted_offset, free_count,
                  min_free, input ready);
  modport sink   (input valid, status, granted_index, granted_offset, free_count,
                  min_free, output ready);
endinterface
`default_nettype wire

FILE: rtl/fbfl_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_cfg: configuration registers
// Holds block size and block count and presents the clamped count.
// ----------------------------------------------------------------------------
module fbfl_cfg
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  logic [SIZE_W-1:0]  blk_bytes;
  logic [COUNT_W-1:0] block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_bytes   <= BLOCK_SIZE_RESET;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BLOCK_SIZE:  blk_bytes   <= cfg_data;
        REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.blk_bytes = blk_bytes;
  assign cfg.eff_count = clamp_count(block_count, MAX_BLOCKS);

endmodule
`default_nettype wire

FILE: rtl/fbfl_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfl_stack: free index stack
// Stack memory with a cached top entry and a low mark below which entries
// still hold their rebuilt value (block i at entry i).
// ----------------------------------------------------------------------------
module fbfl_stack
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  stk_ctl_t  ctl,
  output stk_stat_t stat
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam logic [COUNT_W-1:0] RESET_COUNT = clamp_count(BLOCK_COUNT_RESET, MAX_BLOCKS);

  logic [INDEX_W-1:0] mem [MAX_BLOCKS];
  logic [INDEX_W-1:0] mem_q;

  logic [COUNT_W-1:0] free_count, free_count_next;
  logic [COUNT_W-1:0] low_mark, low_mark_next;
  logic [INDEX_W-1:0] top_reg, top_reg_next;
  logic               top_from_mem, top_from_mem_next;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [COUNT_W-1:0] count_dec;
  logic [COUNT_W-1:0] count_dec2;

  always_comb begin
    count_dec  = free_count - COUNT_W'(1);
    count_dec2 = free_count - COUNT_W'(2);
    free_count_next   = free_count;
    low_mark_next     = low_mark;
    top_reg_next      = top_reg;
    top_from_mem_next = top_from_mem;
    rd_en   = 1'b0;
    rd_addr = AW'(count_dec2);
    if (ctl.rebuild) begin
      free_count_next   = ctl.fill_count;
      low_mark_next     = ctl.fill_count;
      top_reg_next      = INDEX_W'(ctl.fill_count - COUNT_W'(1));
      top_from_mem_next = 1'b0;
    end else if (ctl.push) begin
      free_count_next   = free_count + COUNT_W'(1);
      top_reg_next      = ctl.push_idx;
      top_from_mem_next = 1'b0;
    end else if (ctl.pop) begin
      free_count_next = count_dec;
      if (count_dec < low_mark) begin
        low_mark_next = count_dec;
      end
      // new top is written only if it lies at or above the low mark
      rd_en             = ({1'b0, low_mark} + 8'd2) <= {1'b0, free_count};
      top_from_mem_next = rd_en;
      top_reg_next      = INDEX_W'(count_dec2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= RESET_COUNT;
      low_mark     <= RESET_COUNT;
      top_reg      <= INDEX_W'(RESET_COUNT - COUNT_W'(1));
      top_from_mem <= 1'b0;
    end else begin
      free_count   <= free_count_next;
      low_mark     <= low_mark_next;
      top_reg      <= top_reg_next;
      top_from_mem <= top_from_mem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.rebuild) begin
      mem[AW'(free_count)] <= ctl.push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign stat.free_count = free_count;
  assign stat.top        = top_from_mem ? mem_q : top_reg;

endmodule
`default_nettype wire

FILE: rtl/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a command word accepted goes to the input register, then its
//   response word to the result register, held while the sink stalls.
// Throughput: one command word per cycle, every command, while the sink is
//   ready; free stack memory: one push or one read a cycle, top entry cached.
// Reset: synchronous; registers return to size 64 and count 64, the stack
//   reads as block i at entry i at once through its low mark, no clearing pass.
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator: fixed-size block pool allocator
// Allocates and frees equal blocks from a stack of free block indices and
// reports free count and low-water mark with every response word.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  fbfl_cmd_if.sink                  cmd,
  fbfl_rsp_if.source                rsp
);

  localparam logic [COUNT_W-1:0] RESET_COUNT = clamp_count(BLOCK_COUNT_RESET, MAX_BLOCKS);

  cfg_t      cfg;
  stk_ctl_t  stk_ctl;
  stk_stat_t stk_stat;

  fbfl_cfg #(.MAX_BLOCKS(MAX_BLOCKS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fbfl_stack #(.MAX_BLOCKS(MAX_BLOCKS)) u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (stk_ctl),
    .stat (stk_stat)
  );

  // Input register: hold the accepted command word until the result
  // register can take its response.
  logic               in_valid;
  cmd_t               in_cmd;
  logic [SIZE_W-1:0]  in_req;
  logic [INDEX_W-1:0] in_idx;
  logic               advance;

  // Result register
  logic                out_valid;
  status_t             out_status;
  logic [INDEX_W-1:0]  out_index;
  logic [OFFSET_W-1:0] out_offset;
  logic [COUNT_W-1:0]  out_free;
  logic [COUNT_W-1:0]  out_min;

  logic [COUNT_W-1:0] min_free, min_free_next;

  status_t             status;
  logic [INDEX_W-1:0]  grant_idx;
  logic [OFFSET_W-1:0] grant_off;
  logic [COUNT_W-1:0]  count_after;
  logic                do_pop, do_push, do_rebuild;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_cmd <= cmd_t'(cmd.command);
      in_req <= cmd.request_size;
      in_idx <= cmd.block_index;
    end
  end

  // Command decode: at most one stack operation and the counter update.
  always_comb begin
    status        = ST_OK;
    grant_idx     = '0;
    count_after   = stk_stat.free_count;
    min_free_next = min_free;
    do_pop        = 1'b0;
    do_push       = 1'b0;
    do_rebuild    = 1'b0;
    case (in_cmd)
      CMD_ALLOC: begin
        // size check comes before the empty check
        if (in_req > cfg.blk_bytes) begin
          status = ST_TOO_LARGE;
        end else if (stk_stat.free_count == '0 ||
                     int'(stk_stat.free_count) > MAX_BLOCKS) begin
          status = ST_EXHAUSTED;
        end else begin
          do_pop      = 1'b1;
          grant_idx   = stk_stat.top;
          count_after = stk_stat.free_count - COUNT_W'(1);
        end
      end
      CMD_FREE: begin
        if ({1'b0, in_idx} >= cfg.eff_count) begin
          status = ST_BAD_INDEX;
        end else if (stk_stat.free_count >= cfg.eff_count) begin
          status = ST_OVERFLOW;
        end else begin
          do_push     = 1'b1;
          count_after = stk_stat.free_count + COUNT_W'(1);
        end
      end
      CMD_FREE_ALL: begin
        // rebuild the stack, keep the low-water mark
        do_rebuild  = 1'b1;
        count_after = cfg.eff_count;
      end
      CMD_INIT: begin
        do_rebuild    = 1'b1;
        count_after   = cfg.eff_count;
        min_free_next = cfg.eff_count;
      end
      default: ;
    endcase
    if ((do_pop || do_push) && count_after < min_free) begin
      min_free_next = count_after;
    end
  end

  // 6 x 16 product fits the offset field exactly
  assign grant_off = OFFSET_W'(grant_idx) * OFFSET_W'(cfg.blk_bytes);

  assign stk_ctl.push       = advance && do_push;
  assign stk_ctl.pop        = advance && do_pop;
  assign stk_ctl.rebuild    = advance && do_rebuild;
  assign stk_ctl.push_idx   = in_idx;
  assign stk_ctl.fill_count = cfg.eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_free <= RESET_COUNT;
    end else if (advance) begin
      min_free <= min_free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the response word; hold it while the sink stalls.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status;
      out_index  <= grant_idx;
      out_offset <= grant_off;
      out_free   <= count_after;
      out_min    <= min_free_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted_index  = out_index;
  assign rsp.granted_offset = out_offset;
  assign rsp.free_count     = out_free;
  assign rsp.min_free       = out_min;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: block pool allocator check
// Drives allocate, free, free-all and init words through the command
// channel, rebuilds the free stack, free count and low-water mark alongside
// the block, and compares every response word with the predicted one.
// A short directed table covers the extremes and the error codes; random
// phases under changing pool settings follow.
// ----------------------------------------------------------------------------
module testbench;
  import fbfl_pkg::*;

  localparam int MAX_BLOCKS      = MAX_BLOCKS_DEFAULT;
  localparam int DRAIN_CYCLES    = 4;     // margin after the last response
  localparam int STALL_LIMIT     = 2000;  // cycles without any accepted word
  localparam int RSP_HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int N_PHASES        = 6;
  localparam int PHASE_WORDS     = 150;

  // one response word, field by field
  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  free_blocks;
    logic [COUNT_W-1:0]  low_water;
  } pool_rsp_t;

  typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

  // one row of the directed table: a command word or a register write
  typedef struct {
    row_kind_t         kind;
    cmd_t              cmd;
    logic [SIZE_W-1:0] req;
    logic [INDEX_W-1:0] idx;
    cfg_reg_t          sel;
    logic [SIZE_W-1:0] val;
    bit                has_want;
    pool_rsp_t         want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  fbfl_cmd_if cmd_ch ();
  fbfl_rsp_if rsp_ch ();

  fixed_block_free_list_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  // --------------------------------------------------------------------------
  // Predicted pool state: stack of free indices, counters and both registers
  // --------------------------------------------------------------------------
  logic [INDEX_W-1:0] pool_stack [MAX_BLOCKS];
  logic [COUNT_W-1:0] pool_free;
  logic [COUNT_W-1:0] pool_low;
  logic [SIZE_W-1:0]  pool_size;
  logic [COUNT_W-1:0] pool_count;

  pool_rsp_t          pending_rsp_q [$];  // predicted response words, oldest first
  logic [INDEX_W-1:0] granted_q [$];      // blocks handed out and not yet returned
  stim_row_t          directed_rows [$];

  int error_count;
  int idle_pct;          // chance of an idle burst, shared by both sides
  bit rsp_hold_req;      // ask the receiver for one long hold-off
  int quiet_cycles;

  // Clamp the count register to the depth of the stack.
  function automatic logic [COUNT_W-1:0] usable_blocks();
    return (pool_count > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : pool_count;
  endfunction

  // Refill the stack so entry i holds block i; the low-water mark is left alone.
  function automatic void refill_stack();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      pool_stack[i] = INDEX_W'(i);
    end
    pool_free = usable_blocks();
  endfunction

  // Apply one command word to the predicted pool and return its response.
  function automatic pool_rsp_t apply_pool_command(cmd_t c, logic [SIZE_W-1:0] req,
                                                   logic [INDEX_W-1:0] idx);
    pool_rsp_t   r;
    logic [31:0] prod;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_ALLOC: begin
        if (req > pool_size) begin
          r.status = ST_TOO_LARGE;
        end else if (pool_free == 0 || pool_free > COUNT_W'(MAX_BLOCKS)) begin
          r.status = ST_EXHAUSTED;
        end else begin
          pool_free = pool_free - 1'b1;
          r.index   = pool_stack[pool_free];
          prod      = 32'(r.index) * 32'(pool_size);
          r.offset  = prod[OFFSET_W-1:0];
          if (pool_free < pool_low) pool_low = pool_free;
        end
      end
      CMD_FREE: begin
        if (COUNT_W'(idx) >= usable_blocks()) begin
          r.status = ST_BAD_INDEX;
        end else if (pool_free >= usable_blocks()) begin
          r.status = ST_OVERFLOW;
        end else begin
          pool_stack[pool_free] = idx;
          pool_free = pool_free + 1'b1;
          if (pool_free < pool_low) pool_low = pool_free;
        end
      end
      CMD_FREE_ALL: begin
        refill_stack();
      end
      default: begin
        refill_stack();
        pool_low = pool_free;
      end
    endcase
    r.free_blocks = pool_free;
    r.low_water   = pool_low;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table helpers
  // --------------------------------------------------------------------------
  function automatic stim_row_t word_row(cmd_t c, logic [SIZE_W-1:0] req,
                                         logic [INDEX_W-1:0] idx);
    stim_row_t row;
    row.kind     = ROW_WORD;
    row.cmd      = c;
    row.req      = req;
    row.idx      = idx;
    row.sel      = REG_BLOCK_SIZE;
    row.val      = '0;
    row.has_want = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic stim_row_t checked_row(cmd_t c, logic [SIZE_W-1:0] req,
                                            logic [INDEX_W-1:0] idx, status_t st,
                                            int gidx, int goff, int fc, int low);
    stim_row_t row;
    row = word_row(c, req, idx);
    row.has_want         = 1'b1;
    row.want.status      = st;
    row.want.index       = INDEX_W'(gidx);
    row.want.offset      = OFFSET_W'(goff);
    row.want.free_blocks = COUNT_W'(fc);
    row.want.low_water   = COUNT_W'(low);
    return row;
  endfunction

  function automatic stim_row_t reg_row(cfg_reg_t sel, logic [SIZE_W-1:0] val);
    stim_row_t row;
    row = word_row(CMD_INIT, '0, '0);
    row.kind = ROW_REG;
    row.sel  = sel;
    row.val  = val;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one command word and hold it until accepted; predict its response.
  task automatic send_pool_word(cmd_t c, logic [SIZE_W-1:0] req, logic [INDEX_W-1:0] idx,
                                bit has_want, pool_rsp_t want);
    pool_rsp_t pred;
    @(negedge clk);
    cmd_ch.valid        <= 1'b1;
    cmd_ch.command      <= c;
    cmd_ch.request_size <= req;
    cmd_ch.block_index  <= idx;
    do @(posedge clk); while (!cmd_ch.ready);
    pred = apply_pool_command(c, req, idx);
    pending_rsp_q.push_back(has_want ? want : pred);
    // keep the list of handed-out blocks in step, so frees can return them
    if (c == CMD_ALLOC && pred.status == ST_OK) begin
      granted_q.push_back(pred.index);
    end else if (c == CMD_FREE_ALL || c == CMD_INIT) begin
      granted_q.delete();
    end
  endtask

  // Drop valid for an idle burst, its length given by n.
  task automatic idle_sender(int n);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop offering words and let every outstanding response come back.
  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle; the predictor follows at once.
  task automatic write_pool_reg(cfg_reg_t sel, logic [SIZE_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    if (sel == REG_BLOCK_SIZE) pool_size = val;
    else pool_count = val[COUNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Draw one random word: mostly allocate and free of handed-out blocks,
  // the rest oversize requests, stray frees, free-all and init.
  task automatic pick_random_word(output cmd_t c, output logic [SIZE_W-1:0] req,
                                  output logic [INDEX_W-1:0] idx);
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    req  = SIZE_W'($urandom);
    idx  = INDEX_W'($urandom);
    if (roll < 45) begin
      c   = CMD_ALLOC;
      req = SIZE_W'($urandom_range(0, int'(pool_size)));
    end else if (roll < 80) begin
      c = CMD_FREE;
      if (granted_q.size() != 0) begin
        k   = $urandom_range(0, granted_q.size() - 1);
        idx = granted_q[k];
        granted_q.delete(k);
      end
    end else if (roll < 86) begin
      c = CMD_FREE;
    end else if (roll < 92) begin
      c = CMD_ALLOC;
      if (pool_size != {SIZE_W{1'b1}}) begin
        req = SIZE_W'($urandom_range(int'(pool_size) + 1, 65535));
      end
    end else if (roll < 96) begin
      c = CMD_FREE_ALL;
    end else begin
      c = CMD_INIT;
    end
  endtask

  initial begin
    logic [SIZE_W-1:0]  phase_size  [N_PHASES];
    logic [SIZE_W-1:0]  phase_count [N_PHASES];
    int                 phase_idle  [N_PHASES];
    stim_row_t          row;
    cmd_t               c;
    logic [SIZE_W-1:0]  req;
    logic [INDEX_W-1:0] idx;

    cmd_ch.valid        = 1'b0;
    cmd_ch.command      = CMD_ALLOC;
    cmd_ch.request_size = '0;
    cmd_ch.block_index  = '0;
    cfg_wr_en           = 1'b0;
    cfg_index           = REG_BLOCK_SIZE;
    cfg_data            = '0;
    error_count         = 0;
    idle_pct            = 20;
    rsp_hold_req        = 1'b0;

    // predicted state after reset: size 64, count 64, full stack
    pool_size  = BLOCK_SIZE_RESET;
    pool_count = BLOCK_COUNT_RESET;
    refill_stack();
    pool_low = pool_free;

    // ---- directed table ----
    // reset state: top of stack is the last block
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'd64, 6'h3F, ST_OK, 63, 4032, 63, 63));
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'hFFFF, 6'h00, ST_TOO_LARGE,
                                        0, 0, 63, 63));
    // free-all refills but the low-water mark stays
    directed_rows.push_back(checked_row(CMD_FREE_ALL, 16'hFFFF, 6'h3F, ST_OK, 0, 0, 64, 63));
    directed_rows.push_back(checked_row(CMD_FREE, 16'hFFFF, 6'h00, ST_OVERFLOW,
                                        0, 0, 64, 63));
    directed_rows.push_back(checked_row(CMD_INIT, 16'h0000, 6'h00, ST_OK, 0, 0, 64, 64));
    // largest block, two-block pool
    directed_rows.push_back(reg_row(REG_BLOCK_SIZE, 16'hFFFF));
    directed_rows.push_back(reg_row(REG_BLOCK_COUNT, 16'd2));
    directed_rows.push_back(checked_row(CMD_INIT, 16'h0000, 6'h00, ST_OK, 0, 0, 2, 2));
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'hFFFF, 6'h3F, ST_OK,
                                        1, 65535, 1, 1));
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'h0000, 6'h00, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'h0001, 6'h00, ST_EXHAUSTED,
                                        0, 0, 0, 0));
    directed_rows.push_back(checked_row(CMD_FREE, 16'h0000, 6'h3F, ST_BAD_INDEX,
                                        0, 0, 0, 0));
    directed_rows.push_back(checked_row(CMD_FREE, 16'h0000, 6'h01, ST_OK, 0, 0, 1, 0));
    // a double free slips through as long as the stack has room
    directed_rows.push_back(checked_row(CMD_FREE, 16'h0000, 6'h01, ST_OK, 0, 0, 2, 0));
    directed_rows.push_back(checked_row(CMD_FREE, 16'h0000, 6'h00, ST_OVERFLOW,
                                        0, 0, 2, 0));
    directed_rows.push_back(word_row(CMD_ALLOC, 16'd5, 6'h00));
    // count above the stack depth clamps to it
    directed_rows.push_back(reg_row(REG_BLOCK_COUNT, 16'd127));
    directed_rows.push_back(checked_row(CMD_FREE_ALL, 16'h0000, 6'h00, ST_OK, 0, 0, 64, 0));
    directed_rows.push_back(word_row(CMD_ALLOC, 16'h0000, 6'h00));
    // empty pool
    directed_rows.push_back(reg_row(REG_BLOCK_COUNT, 16'd0));
    directed_rows.push_back(checked_row(CMD_INIT, 16'h0000, 6'h00, ST_OK, 0, 0, 0, 0));
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'h0000, 6'h00, ST_EXHAUSTED,
                                        0, 0, 0, 0));
    directed_rows.push_back(checked_row(CMD_FREE, 16'h0000, 6'h00, ST_BAD_INDEX,
                                        0, 0, 0, 0));
    // zero block size: only empty requests fit
    directed_rows.push_back(reg_row(REG_BLOCK_SIZE, 16'd0));
    directed_rows.push_back(reg_row(REG_BLOCK_COUNT, 16'd64));
    directed_rows.push_back(checked_row(CMD_INIT, 16'h0000, 6'h00, ST_OK, 0, 0, 64, 64));
    directed_rows.push_back(checked_row(CMD_ALLOC, 16'h0001, 6'h00, ST_TOO_LARGE,
                                        0, 0, 64, 64));
    directed_rows.push_back(word_row(CMD_ALLOC, 16'h0000, 6'h2A));

    wait (rst == 1'b0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        write_pool_reg(row.sel, row.val);
      end else begin
        if ($urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 15));
        send_pool_word(row.cmd, row.req, row.idx, row.has_want, row.want);
      end
    end

    // ---- random phases ----
    // extremes first, then mid-range settings; the last phase returns to the largest size and runs flat out
    phase_size  = '{16'hFFFF, 16'd64, 16'd1, SIZE_W'($urandom_range(2, 65534)),
                    SIZE_W'($urandom_range(1, 1024)), 16'hFFFF};
    phase_count = '{16'd64, 16'd1, 16'd127, 16'd3,
                    SIZE_W'($urandom_range(1, MAX_BLOCKS)), 16'd64};
    phase_idle  = '{30, 50, 0, 20, 40, 0};

    for (int p = 0; p < N_PHASES; p++) begin
      write_pool_reg(REG_BLOCK_SIZE, phase_size[p]);
      write_pool_reg(REG_BLOCK_COUNT, phase_count[p]);
      idle_pct = phase_idle[p];
      // the fourth phase keeps the stale stack left by the previous settings
      if (p != 3) send_pool_word(CMD_INIT, SIZE_W'($urandom), INDEX_W'($urandom), 1'b0, '0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold the receiver off while words keep coming, to fill the pipe
        if (p == 1 && n == 20) rsp_hold_req = 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          idle_sender($urandom_range(1, 15));
        end
        pick_random_word(c, req, idx);
        send_pool_word(c, req, idx, 1'b0, '0);
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("fixed_block_free_list_allocator verification clean");
    end else begin
      $display("fixed_block_free_list_allocator verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: ready in random bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (rsp_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES - 1) @(negedge clk);
        rsp_hold_req = 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response check: every accepted word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    pool_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        flag_mismatch("response word with nothing pending");
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("status", rsp_ch.status, want.status);
        check_field("granted_index", rsp_ch.granted_index, want.index);
        check_field("granted_offset", rsp_ch.granted_offset, want.offset);
        check_field("free_count", rsp_ch.free_count, want.free_blocks);
        check_field("min_free", rsp_ch.min_free, want.low_water);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves a word for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("fixed_block_free_list_allocator verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
